// File: design/lmed_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// List-mode event deframer package
// Shared types, result codes and the fixed test pattern table.
// ============================================================================
package lmed_pkg;

    // Result kinds as seen on the event channel.
    typedef enum logic [2:0] {
        KIND_PAT_OK   = 3'd0,
        KIND_PAT_FLAW = 3'd1,
        KIND_NO_MATCH = 3'd2,
        KIND_TIME_TAG = 3'd3,
        KIND_SGL_TAG  = 3'd4,
        KIND_OTH_TAG  = 3'd5,
        KIND_SYNC_ERR = 3'd6
    } t_kind;

    // Head byte decoding constants.
    localparam logic [7:0] HEAD_FLAG   = 8'h80;
    localparam logic [7:0] TAG_MASK    = 8'he0;
    localparam logic [7:0] TAG_TIME    = 8'h80;
    localparam logic [7:0] TAG_SINGLES = 8'ha0;

    // Test pattern table: one row per entry, checked in order.
    localparam int PAT_ROWS = 4;
    localparam int PAT_IDX_W = $clog2(PAT_ROWS);
    localparam logic [7:0] PAT_B0 [PAT_ROWS] = '{8'h39, 8'h71, 8'hc3, 8'h55};
    localparam logic [7:0] PAT_B1 [PAT_ROWS] = '{8'h17, 8'h47, 8'h59, 8'h33};
    localparam logic [7:0] PAT_B2 [PAT_ROWS] = '{8'h63, 8'ha3, 8'hd4, 8'h0f};

    // One list-mode word.
    typedef struct packed {
        logic [7:0] head;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } t_word;

    // Classification of one assembled event.
    typedef struct packed {
        t_kind                 kind;
        logic [PAT_IDX_W-1:0]  pattern_index;
        logic [23:0]           time_value;
        logic [9:0]            block_number;
        logic [18:0]           count_rate;
    } t_decode;

    // One result item.
    typedef struct packed {
        t_decode     dec;
        t_word       evt;
        logic [31:0] events_seen;
        logic [31:0] sync_errors_seen;
    } t_result;

endpackage

// File: design/lmed_if.sv
`timescale 1ns / 1ps
// ============================================================================
// List-mode event deframer channels
// Valid/ready channels for words, configuration and result events.
// ============================================================================

// Incoming list-mode words.
interface lmed_word_if;
    logic       valid;
    logic       ready;
    logic [7:0] word_head;
    logic [7:0] word_byte0;
    logic [7:0] word_byte1;
    logic [7:0] word_byte2;

    modport source (output valid, word_head, word_byte0, word_byte1, word_byte2,
                    input ready);
    modport sink   (input valid, word_head, word_byte0, word_byte1, word_byte2,
                    output ready);
endinterface

// Configuration write channel carrying the pair mode register.
interface lmed_cfg_if;
    logic valid;
    logic ready;
    logic pair_mode;

    modport source (output valid, pair_mode, input ready);
    modport sink   (input valid, pair_mode, output ready);
endinterface

// Outgoing decoded events.
interface lmed_evt_if;
    logic                          valid;
    logic                          ready;
    lmed_pkg::t_kind               kind;
    logic [7:0]                    event_head;
    logic [7:0]                    event_b0;
    logic [7:0]                    event_b1;
    logic [7:0]                    event_b2;
    logic [lmed_pkg::PAT_IDX_W-1:0] pattern_index;
    logic [23:0]                   time_value;
    logic [9:0]                    block_number;
    logic [18:0]                   count_rate;
    logic [31:0]                   events_seen;
    logic [31:0]                   sync_errors_seen;

    modport source (output valid, kind, event_head, event_b0, event_b1, event_b2,
                    pattern_index, time_value, block_number, count_rate,
                    events_seen, sync_errors_seen,
                    input ready);
    modport sink   (input valid, kind, event_head, event_b0, event_b1, event_b2,
                    pattern_index, time_value, block_number, count_rate,
                    events_seen, sync_errors_seen,
                    output ready);
endinterface

// File: design/list_mode_event_deframer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// List-mode event deframer
// Pairs list-mode words, resynchronises on bad pairs, decodes tags and checks
// regular events against a fixed test pattern table.
// ============================================================================
// The block accepts one list-mode word per clock cycle, sustained, while the
// result channel does not stall. An accepted word waits in the input register;
// its result is then registered in the result register and offered on the
// event channel from there. Word pairing, tag decoding, the pattern check and
// the next values of both 32-bit counters are settled combinationally
// between those two registers. In pair mode the first word of a
// pair gives no result; a word without head bit 7 in second place drops the
// held word with a sync error result and takes its place. Writing the pair
// mode register discards any held word and must only be done while the block
// is idle. Back-pressure on the result channel stalls both registers in turn.
module list_mode_event_deframer_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lmed_word_if.sink        i_word,
    lmed_cfg_if.sink         i_cfg,
    lmed_evt_if.source       o_evt
);

    // Pipeline handshakes.
    logic              r_in_valid;
    lmed_pkg::t_word   r_in;
    logic              r_out_valid;
    lmed_pkg::t_result r_out;
    logic              s2_adv;
    logic              s2_fire;

    // Deframer state.
    logic              r_pair_mode;
    logic              r_held_valid;
    lmed_pkg::t_word   r_held;
    logic [31:0]       r_event_total;
    logic [31:0]       r_sync_total;

    // Next-state values of the processing stage.
    logic              n_emit;
    logic              n_held_valid;
    logic              n_load_held;
    logic              n_sync_err;
    logic              n_event_inc;
    lmed_pkg::t_word   n_evt;
    logic              n_tag_en;
    lmed_pkg::t_decode dec;
    logic [31:0]       n_event_total;
    logic [31:0]       n_sync_total;
    lmed_pkg::t_result n_out;

    assign s2_adv       = !r_out_valid || o_evt.ready;
    assign s2_fire      = r_in_valid && s2_adv;
    assign i_word.ready = !r_in_valid || s2_adv;
    assign i_cfg.ready  = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_word.ready) begin
            r_in_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.valid && i_word.ready) begin
            r_in <= '{head:  i_word.word_head,  byte0: i_word.word_byte0,
                      byte1: i_word.word_byte1, byte2: i_word.word_byte2};
        end
    end

    // Pairing and resynchronisation decision for the word in the input register.
    always_comb begin
        n_emit       = 1'b0;
        n_held_valid = r_held_valid;
        n_load_held  = 1'b0;
        n_sync_err   = 1'b0;
        n_event_inc  = 1'b0;
        n_tag_en     = 1'b0;
        n_evt        = r_in;
        if (!r_pair_mode) begin
            n_emit      = 1'b1;
            n_event_inc = 1'b1;
        end else if (!r_held_valid) begin
            n_held_valid = 1'b1;
            n_load_held  = 1'b1;
        end else if ((r_in.head & lmed_pkg::HEAD_FLAG) == 8'h00) begin
            n_emit      = 1'b1;
            n_sync_err  = 1'b1;
            n_load_held = 1'b1;
            n_evt       = r_held;
        end else begin
            n_emit       = 1'b1;
            n_event_inc  = 1'b1;
            n_held_valid = 1'b0;
            n_tag_en     = 1'b1;
            n_evt        = '{head:  r_in.byte1,   byte0: r_in.byte2,
                             byte1: r_held.byte1, byte2: r_held.byte2};
        end
    end

    lmed_decode u_decode (
        .i_evt    (n_evt),
        .i_tag_en (n_tag_en),
        .o_dec    (dec)
    );

    // Running counters and result assembly.
    always_comb begin
        n_event_total = r_event_total + {31'd0, n_event_inc};
        n_sync_total  = r_sync_total + {31'd0, n_sync_err};
        n_out.evt              = n_evt;
        n_out.events_seen      = n_event_total;
        n_out.sync_errors_seen = n_sync_total;
        if (n_sync_err) begin
            n_out.dec      = '0;
            n_out.dec.kind = lmed_pkg::KIND_SYNC_ERR;
        end else begin
            n_out.dec = dec;
        end
    end

    // State registers; a configuration write drops any held word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_mode   <= 1'b0;
            r_held_valid  <= 1'b0;
            r_event_total <= '0;
            r_sync_total  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_pair_mode  <= i_cfg.pair_mode;
            r_held_valid <= 1'b0;
        end else if (s2_fire) begin
            r_held_valid  <= n_held_valid;
            r_event_total <= n_event_total;
            r_sync_total  <= n_sync_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && n_load_held) begin
            r_held <= r_in;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= s2_fire && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_evt.valid            = r_out_valid;
    assign o_evt.kind             = r_out.dec.kind;
    assign o_evt.event_head       = r_out.evt.head;
    assign o_evt.event_b0         = r_out.evt.byte0;
    assign o_evt.event_b1         = r_out.evt.byte1;
    assign o_evt.event_b2         = r_out.evt.byte2;
    assign o_evt.pattern_index    = r_out.dec.pattern_index;
    assign o_evt.time_value       = r_out.dec.time_value;
    assign o_evt.block_number     = r_out.dec.block_number;
    assign o_evt.count_rate       = r_out.dec.count_rate;
    assign o_evt.events_seen      = r_out.events_seen;
    assign o_evt.sync_errors_seen = r_out.sync_errors_seen;

    // Sync errors can only be counted in pair mode.
    a_sync_only_paired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pair_mode |=> $stable(r_sync_total))
        else $error("sync error counter moved outside pair mode");

    // One word never bumps both counters.
    a_one_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> !((r_event_total != $past(r_event_total)) &&
                   (r_sync_total != $past(r_sync_total))))
        else $error("event and sync counters advanced together");

    // The first word of a pair gives no result.
    a_first_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && r_pair_mode && !r_held_valid) |=> !r_out_valid)
        else $error("result produced for the first word of a pair");

    // A sync error keeps a word held for the next pairing attempt.
    a_sync_keeps_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && n_sync_err && !i_cfg.valid) |=> r_held_valid)
        else $error("held word lost on sync error");

endmodule

// File: design/lmed_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// List-mode event classifier
// Decodes tag events and checks regular events against the test patterns.
// ============================================================================
module lmed_decode (
    input  lmed_pkg::t_word   i_evt,
    input  logic              i_tag_en,
    output lmed_pkg::t_decode o_dec
);

    logic [lmed_pkg::PAT_ROWS-1:0] hit;
    logic [lmed_pkg::PAT_ROWS-1:0] exact;

    // Per-row compares are independent of each other.
    always_comb begin
        for (int r = 0; r < lmed_pkg::PAT_ROWS; r++) begin
            hit[r]   = (i_evt.byte0 == lmed_pkg::PAT_B0[r]) ||
                       (i_evt.byte1 == lmed_pkg::PAT_B1[r]) ||
                       (i_evt.byte2 == lmed_pkg::PAT_B2[r]);
            exact[r] = (i_evt.byte0 == lmed_pkg::PAT_B0[r]) &&
                       (i_evt.byte1 == lmed_pkg::PAT_B1[r]) &&
                       (i_evt.byte2 == lmed_pkg::PAT_B2[r]);
        end
    end

    // Tags take priority when enabled; otherwise the first hitting row wins.
    always_comb begin
        logic found;
        found = 1'b0;
        o_dec = '0;
        o_dec.kind = lmed_pkg::KIND_NO_MATCH;
        if (i_tag_en && ((i_evt.head & lmed_pkg::HEAD_FLAG) != 8'h00)) begin
            if ((i_evt.head & lmed_pkg::TAG_MASK) == lmed_pkg::TAG_TIME) begin
                o_dec.kind       = lmed_pkg::KIND_TIME_TAG;
                o_dec.time_value = {i_evt.byte0, i_evt.byte1, i_evt.byte2};
            end else if ((i_evt.head & lmed_pkg::TAG_MASK) == lmed_pkg::TAG_SINGLES) begin
                o_dec.kind         = lmed_pkg::KIND_SGL_TAG;
                o_dec.block_number = {i_evt.head[4:0], i_evt.byte0[7:3]};
                o_dec.count_rate   = {i_evt.byte0[2:0], i_evt.byte1, i_evt.byte2};
            end else begin
                o_dec.kind = lmed_pkg::KIND_OTH_TAG;
            end
        end else begin
            for (int r = 0; r < lmed_pkg::PAT_ROWS; r++) begin
                if (!found && hit[r]) begin
                    found               = 1'b1;
                    o_dec.pattern_index = lmed_pkg::PAT_IDX_W'(r);
                    o_dec.kind          = exact[r] ? lmed_pkg::KIND_PAT_OK
                                                   : lmed_pkg::KIND_PAT_FLAW;
                end
            end
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// List-mode event deframer testbench
// Drives list-mode words in single-word and paired mode through valid/ready
// channels with bursty sending and a stalling receiver. A built-in predictor
// of pairing, resynchronisation, tag decoding and the test pattern check
// works out each expected event, and every event leaving the block is checked
// field by field against the oldest outstanding expectation.
// ============================================================================
module tb_top;

    // A step of the directed list: a word request or a pair mode write.
    typedef enum logic [0:0] {
        STEP_WORD = 1'b0,
        STEP_CFG  = 1'b1
    } t_step_op;

    typedef struct packed {
        t_step_op          op;
        logic              mode;
        lmed_pkg::t_word   word;
        logic              fixed;
        lmed_pkg::t_result exp;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    lmed_word_if wif ();
    lmed_cfg_if  cif ();
    lmed_evt_if  eif ();

    list_mode_event_deframer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (wif),
        .i_cfg   (cif),
        .o_evt   (eif)
    );

    // Predictor state: register copy, held first word and both counters.
    logic            pair_on;
    logic            held_valid;
    lmed_pkg::t_word held_word;
    logic [31:0]     event_total;
    logic [31:0]     sync_total;

    lmed_pkg::t_result pending_events [$];
    t_step             directed_steps [$];
    int                errors;
    int                burst_left;
    int                pair_row;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous bound on the whole run.
    initial begin
        #1000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Test pattern check on the three data bytes of an event.
    function automatic lmed_pkg::t_decode pattern_decode(input logic [7:0] b0,
                                                         input logic [7:0] b1,
                                                         input logic [7:0] b2);
        lmed_pkg::t_decode d;
        bit                hit;
        d      = '0;
        d.kind = lmed_pkg::KIND_NO_MATCH;
        hit    = 1'b0;
        for (int r = 0; r < lmed_pkg::PAT_ROWS; r++) begin
            if (!hit && (b0 == lmed_pkg::PAT_B0[r] || b1 == lmed_pkg::PAT_B1[r] ||
                         b2 == lmed_pkg::PAT_B2[r])) begin
                hit             = 1'b1;
                d.pattern_index = lmed_pkg::PAT_IDX_W'(r);
                if (b0 == lmed_pkg::PAT_B0[r] && b1 == lmed_pkg::PAT_B1[r] &&
                    b2 == lmed_pkg::PAT_B2[r]) begin
                    d.kind = lmed_pkg::KIND_PAT_OK;
                end else begin
                    d.kind = lmed_pkg::KIND_PAT_FLAW;
                end
            end
        end
        return d;
    endfunction

    // Works out the event caused by one accepted word; returns 0 when the word
    // is only held as the first half of a pair.
    function automatic bit predict_event(input lmed_pkg::t_word w,
                                         output lmed_pkg::t_result r);
        r = '0;
        if (!pair_on) begin
            event_total = event_total + 32'd1;
            r.evt       = w;
            r.dec       = pattern_decode(w.byte0, w.byte1, w.byte2);
        end else if (!held_valid) begin
            held_word  = w;
            held_valid = 1'b1;
            return 1'b0;
        end else if (!w.head[7]) begin
            // Out of step: drop the held word and keep the new one in its place.
            sync_total = sync_total + 32'd1;
            r.dec.kind = lmed_pkg::KIND_SYNC_ERR;
            r.evt      = held_word;
            held_word  = w;
        end else begin
            r.evt       = {w.byte1, w.byte2, held_word.byte1, held_word.byte2};
            held_valid  = 1'b0;
            event_total = event_total + 32'd1;
            if (!r.evt.head[7]) begin
                r.dec = pattern_decode(r.evt.byte0, r.evt.byte1, r.evt.byte2);
            end else if ((r.evt.head & lmed_pkg::TAG_MASK) == lmed_pkg::TAG_TIME) begin
                r.dec.kind       = lmed_pkg::KIND_TIME_TAG;
                r.dec.time_value = {r.evt.byte0, r.evt.byte1, r.evt.byte2};
            end else if ((r.evt.head & lmed_pkg::TAG_MASK) == lmed_pkg::TAG_SINGLES) begin
                r.dec.kind         = lmed_pkg::KIND_SGL_TAG;
                r.dec.block_number = {r.evt.head[4:0], r.evt.byte0[7:3]};
                r.dec.count_rate   = {r.evt.byte0[2:0], r.evt.byte1, r.evt.byte2};
            end else begin
                r.dec.kind = lmed_pkg::KIND_OTH_TAG;
            end
        end
        r.events_seen      = event_total;
        r.sync_errors_seen = sync_total;
        return 1'b1;
    endfunction

    function automatic lmed_pkg::t_result mk_res(input lmed_pkg::t_kind k,
                                                 input logic [31:0] evt,
                                                 input logic [1:0] idx,
                                                 input logic [23:0] tv,
                                                 input logic [9:0] blk,
                                                 input logic [18:0] rate,
                                                 input logic [31:0] seen,
                                                 input logic [31:0] syncs);
        lmed_pkg::t_result r;
        r                      = '0;
        r.dec.kind             = k;
        r.dec.pattern_index    = idx;
        r.dec.time_value       = tv;
        r.dec.block_number     = blk;
        r.dec.count_rate       = rate;
        r.evt                  = evt;
        r.events_seen          = seen;
        r.sync_errors_seen     = syncs;
        return r;
    endfunction

    function automatic t_step word_row(input logic [31:0] w);
        t_step s;
        s      = '0;
        s.op   = STEP_WORD;
        s.word = w;
        return s;
    endfunction

    function automatic t_step fixed_row(input logic [31:0] w, input lmed_pkg::t_result e);
        t_step s;
        s       = word_row(w);
        s.fixed = 1'b1;
        s.exp   = e;
        return s;
    endfunction

    function automatic t_step cfg_row(input logic m);
        t_step s;
        s      = '0;
        s.op   = STEP_CFG;
        s.mode = m;
        return s;
    endfunction

    // A byte that often hits the pattern table in the given column.
    function automatic logic [7:0] pick_byte(input int col);
        int r;
        r = $urandom_range(0, lmed_pkg::PAT_ROWS - 1);
        if ($urandom_range(0, 99) < 35) begin
            case (col)
                0:       return lmed_pkg::PAT_B0[r];
                1:       return lmed_pkg::PAT_B1[r];
                default: return lmed_pkg::PAT_B2[r];
            endcase
        end
        return 8'($urandom);
    endfunction

    // Random word shaped by the mode and by whether a first word is held.
    function automatic lmed_pkg::t_word gen_word();
        lmed_pkg::t_word w;
        int              r;
        w = lmed_pkg::t_word'($urandom);
        r = $urandom_range(0, lmed_pkg::PAT_ROWS - 1);
        if (!pair_on) begin
            if ($urandom_range(0, 99) < 15) begin
                w.byte0 = lmed_pkg::PAT_B0[r];
                w.byte1 = lmed_pkg::PAT_B1[r];
                w.byte2 = lmed_pkg::PAT_B2[r];
            end else begin
                w.byte0 = pick_byte(0);
                w.byte1 = pick_byte(1);
                w.byte2 = pick_byte(2);
            end
        end else if (!held_valid) begin
            // First half of a pair: its bytes 1 and 2 become event bytes 1 and 2.
            pair_row = ($urandom_range(0, 99) < 20) ? r : -1;
            if (pair_row >= 0) begin
                w.byte1 = lmed_pkg::PAT_B1[pair_row];
                w.byte2 = lmed_pkg::PAT_B2[pair_row];
            end else begin
                w.byte1 = pick_byte(1);
                w.byte2 = pick_byte(2);
            end
        end else begin
            case ($urandom_range(0, 3))
                0:       w.byte1 = {1'b0, 7'($urandom)};
                1:       w.byte1 = {3'b100, 5'($urandom)};
                2:       w.byte1 = {3'b101, 5'($urandom)};
                default: w.byte1 = 8'($urandom);
            endcase
            if (pair_row >= 0) begin
                w.byte1[7] = 1'b0;
                w.byte2    = lmed_pkg::PAT_B0[pair_row];
            end else begin
                w.byte2 = pick_byte(0);
            end
            // Mostly well-formed second words; some break the pairing.
            w.head[7] = ($urandom_range(0, 99) >= 15);
        end
        return w;
    endfunction

    // Sends one word request in bursts; entered and left at a falling edge.
    task automatic issue_word(input lmed_pkg::t_word w, input logic fixed,
                              input lmed_pkg::t_result fixed_exp);
        lmed_pkg::t_result r;
        int                gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                wif.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 12);
        end
        burst_left     = burst_left - 1;
        wif.valid      = 1'b1;
        wif.word_head  = w.head;
        wif.word_byte0 = w.byte0;
        wif.word_byte1 = w.byte1;
        wif.word_byte2 = w.byte2;
        @(posedge i_clk);
        while (!wif.ready) @(posedge i_clk);
        if (predict_event(w, r)) begin
            pending_events.push_back(fixed ? fixed_exp : r);
        end
        @(negedge i_clk);
    endtask

    // Lets the block drain before a register write.
    task automatic wait_drained();
        wif.valid = 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_pair_mode(input logic m);
        wait_drained();
        cif.valid     = 1'b1;
        cif.pair_mode = m;
        @(posedge i_clk);
        while (!cif.ready) @(posedge i_clk);
        pair_on    = m;
        held_valid = 1'b0;
        @(negedge i_clk);
        cif.valid = 1'b0;
    endtask

    function automatic bit field_ok(input string nm, input logic [31:0] e,
                                    input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Result side: every accepted event against the oldest expectation.
    always @(posedge i_clk) begin
        lmed_pkg::t_result e;
        bit                good;
        if (i_rst_n && eif.valid === 1'b1 && eif.ready === 1'b1) begin
            if (pending_events.size() == 0) begin
                $display("%0t: event with no expectation, expected none, actual kind %0d",
                         $time, eif.kind);
                errors = errors + 1;
            end else begin
                e    = pending_events.pop_front();
                good = 1'b1;
                good &= field_ok("kind", e.dec.kind, eif.kind);
                good &= field_ok("event_head", e.evt.head, eif.event_head);
                good &= field_ok("event_b0", e.evt.byte0, eif.event_b0);
                good &= field_ok("event_b1", e.evt.byte1, eif.event_b1);
                good &= field_ok("event_b2", e.evt.byte2, eif.event_b2);
                good &= field_ok("pattern_index", e.dec.pattern_index, eif.pattern_index);
                good &= field_ok("time_value", e.dec.time_value, eif.time_value);
                good &= field_ok("block_number", e.dec.block_number, eif.block_number);
                good &= field_ok("count_rate", e.dec.count_rate, eif.count_rate);
                good &= field_ok("events_seen", e.events_seen, eif.events_seen);
                good &= field_ok("sync_errors_seen", e.sync_errors_seen,
                                 eif.sync_errors_seen);
                if (!good) errors = errors + 1;
            end
        end
    end

    // Receiver stalls: always ready, a rotating pattern, or coin flips.
    initial begin
        int          span;
        int          style;
        logic [12:0] stall_pat;
        eif.ready = 1'b0;
        span      = 0;
        style     = 0;
        stall_pat = 13'b1011001110101;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                style = $urandom_range(0, 2);
                span  = $urandom_range(20, 80);
            end
            span      = span - 1;
            stall_pat = {stall_pat[11:0], stall_pat[12]};
            case (style)
                0:       eif.ready = 1'b1;
                1:       eif.ready = stall_pat[0];
                default: eif.ready = 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Stimulus.
    initial begin
        t_step s;
        int    n;
        i_rst_n        = 1'b0;
        wif.valid      = 1'b0;
        wif.word_head  = '0;
        wif.word_byte0 = '0;
        wif.word_byte1 = '0;
        wif.word_byte2 = '0;
        cif.valid      = 1'b0;
        cif.pair_mode  = 1'b0;
        pair_on        = 1'b0;
        held_valid     = 1'b0;
        held_word      = '0;
        event_total    = '0;
        sync_total     = '0;
        errors         = 0;
        burst_left     = 0;
        pair_row       = -1;

        // Single-word mode straight after reset: extremes, exact rows, a flaw.
        directed_steps.push_back(fixed_row(32'h00000000,
            mk_res(lmed_pkg::KIND_NO_MATCH, 32'h00000000, 2'd0, 24'h0, 10'd0, 19'h0,
                   32'd1, 32'd0)));
        directed_steps.push_back(fixed_row(32'hffffffff,
            mk_res(lmed_pkg::KIND_NO_MATCH, 32'hffffffff, 2'd0, 24'h0, 10'd0, 19'h0,
                   32'd2, 32'd0)));
        directed_steps.push_back(fixed_row(32'h12391763,
            mk_res(lmed_pkg::KIND_PAT_OK, 32'h12391763, 2'd0, 24'h0, 10'd0, 19'h0,
                   32'd3, 32'd0)));
        directed_steps.push_back(fixed_row(32'h0055330f,
            mk_res(lmed_pkg::KIND_PAT_OK, 32'h0055330f, 2'd3, 24'h0, 10'd0, 19'h0,
                   32'd4, 32'd0)));
        // A set head bit is not a tag in single-word mode.
        directed_steps.push_back(fixed_row(32'h80c30000,
            mk_res(lmed_pkg::KIND_PAT_FLAW, 32'h80c30000, 2'd2, 24'h0, 10'd0, 19'h0,
                   32'd5, 32'd0)));
        directed_steps.push_back(word_row(32'h7f7147a3));
        // Paired mode: time tag, largest singles tag, other tag, regular event.
        directed_steps.push_back(cfg_row(1'b1));
        directed_steps.push_back(word_row(32'h00001234));
        directed_steps.push_back(fixed_row(32'h80008056,
            mk_res(lmed_pkg::KIND_TIME_TAG, 32'h80561234, 2'd0, 24'h561234, 10'd0, 19'h0,
                   32'd7, 32'd0)));
        directed_steps.push_back(word_row(32'h0000ffff));
        directed_steps.push_back(fixed_row(32'hff00bfff,
            mk_res(lmed_pkg::KIND_SGL_TAG, 32'hbfffffff, 2'd0, 24'h0, 10'd1023, 19'h7ffff,
                   32'd8, 32'd0)));
        directed_steps.push_back(word_row(32'h11223344));
        directed_steps.push_back(word_row(32'h8000e566));
        directed_steps.push_back(word_row(32'h00001763));
        directed_steps.push_back(word_row(32'h80001239));
        // Loss of sync twice in a row, then a pair completes on the held word.
        directed_steps.push_back(word_row(32'haabbccdd));
        directed_steps.push_back(fixed_row(32'h7f010203,
            mk_res(lmed_pkg::KIND_SYNC_ERR, 32'haabbccdd, 2'd0, 24'h0, 10'd0, 19'h0,
                   32'd10, 32'd1)));
        directed_steps.push_back(word_row(32'h00000000));
        directed_steps.push_back(word_row(32'h80ff8000));
        // A register write throws away a held first word.
        directed_steps.push_back(word_row(32'h5a5a5a5a));
        directed_steps.push_back(cfg_row(1'b1));
        directed_steps.push_back(word_row(32'h01020304));
        directed_steps.push_back(word_row(32'h80000000));
        directed_steps.push_back(cfg_row(1'b0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[k]) begin
            s = directed_steps[k];
            if (s.op == STEP_CFG) begin
                write_pair_mode(s.mode);
            end else begin
                issue_word(s.word, s.fixed, s.exp);
            end
        end

        // Random phases, mostly paired mode where the deeper behaviour lies.
        for (int p = 0; p < 6; p++) begin
            write_pair_mode((p % 3) != 1);
            for (int i = 0; i < 100; i++) begin
                issue_word(gen_word(), 1'b0, '0);
            end
        end

        wif.valid = 1'b0;
        n = 0;
        while (pending_events.size() != 0 && n < 5000) begin
            @(negedge i_clk);
            n = n + 1;
        end
        repeat (6) @(negedge i_clk);
        if (pending_events.size() != 0) begin
            $display("%0t: events never seen, expected %0d more, actual none", $time,
                     pending_events.size());
            errors = errors + 1;
        end
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
